/* hdl/bsmd_pkg.sv */
// Shared types, bank map table and RAM fill function for the bank-switched
// memory decoder. No dependencies.
package bsmd_pkg;

  // bus target codes as reported on the target port
  typedef enum logic [3:0] {
    TGT_RAM      = 4'd0,
    TGT_ROM      = 4'd1,
    TGT_COLOR    = 4'd2,
    TGT_VIC      = 4'd3,
    TGT_SID      = 4'd4,
    TGT_CIA1     = 4'd5,
    TGT_CIA2     = 4'd6,
    TGT_IO1      = 4'd7,
    TGT_IO2      = 4'd8,
    TGT_CARTLO   = 4'd9,
    TGT_CARTHI   = 4'd10,
    TGT_PORTDIR  = 4'd11,
    TGT_PORTDATA = 4'd12,
    TGT_OPENBUS  = 4'd13
  } target_t;

  // bank source kinds held in the bank map
  typedef enum logic [2:0] {
    K_R = 3'd0,  // RAM
    K_O = 3'd1,  // ROM (writes fall through to RAM)
    K_I = 3'd2,  // I/O
    K_L = 3'd3,  // cartridge low
    K_H = 3'd4,  // cartridge high
    K_N = 3'd5   // open bus
  } kind_t;

  // where the result byte comes from
  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_RAM   = 3'd1,
    SRC_COLOR = 3'd2,
    SRC_OBUS  = 3'd3,
    SRC_WDATA = 3'd4
  } src_t;

  typedef kind_t map_row_t [6];

  // indexed by {exrom, game, port_bits}; columns per bank group
  localparam map_row_t REGION_MAP [32] = '{
    '{K_R,K_R,K_R,K_R,K_R,K_R}, '{K_R,K_R,K_R,K_R,K_R,K_R},
    '{K_R,K_R,K_H,K_R,K_O,K_O}, '{K_R,K_L,K_H,K_R,K_O,K_O},
    '{K_R,K_R,K_R,K_R,K_R,K_R}, '{K_R,K_R,K_R,K_R,K_I,K_R},
    '{K_R,K_R,K_H,K_R,K_I,K_O}, '{K_R,K_L,K_H,K_R,K_I,K_O},
    '{K_R,K_R,K_R,K_R,K_R,K_R}, '{K_R,K_R,K_R,K_R,K_O,K_R},
    '{K_R,K_R,K_R,K_R,K_O,K_O}, '{K_R,K_L,K_O,K_R,K_O,K_O},
    '{K_R,K_R,K_R,K_R,K_R,K_R}, '{K_R,K_R,K_R,K_R,K_I,K_R},
    '{K_R,K_R,K_R,K_R,K_I,K_O}, '{K_R,K_L,K_O,K_R,K_I,K_O},
    '{K_N,K_L,K_N,K_N,K_I,K_H}, '{K_N,K_L,K_N,K_N,K_I,K_H},
    '{K_N,K_L,K_N,K_N,K_I,K_H}, '{K_N,K_L,K_N,K_N,K_I,K_H},
    '{K_N,K_L,K_N,K_N,K_I,K_H}, '{K_N,K_L,K_N,K_N,K_I,K_H},
    '{K_N,K_L,K_N,K_N,K_I,K_H}, '{K_N,K_L,K_N,K_N,K_I,K_H},
    '{K_R,K_R,K_R,K_R,K_R,K_R}, '{K_R,K_R,K_R,K_R,K_O,K_R},
    '{K_R,K_R,K_R,K_R,K_O,K_O}, '{K_R,K_R,K_O,K_R,K_O,K_O},
    '{K_R,K_R,K_R,K_R,K_R,K_R}, '{K_R,K_R,K_R,K_R,K_I,K_R},
    '{K_R,K_R,K_R,K_R,K_I,K_O}, '{K_R,K_R,K_O,K_R,K_I,K_O}
  };

  localparam logic [15:0] SCREEN_LO  = 16'h0400;
  localparam logic [15:0] SCREEN_END = 16'h07E8;  // 1000 bytes of 0x01
  localparam logic [7:0]  SCREEN_VAL = 8'h01;

  // decoded access, passed from the decoder to the pipeline
  typedef struct packed {
    target_t     target;
    logic [15:0] dev;
    logic        ram_en;
    logic        ram_we;
    logic        col_en;
    logic        col_we;
    src_t        src;
  } dec_t;

  // column of the bank map for banks 1..15
  function automatic logic [2:0] bank_col(input logic [3:0] bank);
    logic [2:0] c;
    case (bank) inside
      [4'd0:4'd7]:  c = 3'd0;
      4'd8, 4'd9:   c = 3'd1;
      4'd10, 4'd11: c = 3'd2;
      4'd12:        c = 3'd3;
      4'd13:        c = 3'd4;
      default:      c = 3'd5;
    endcase
    return c;
  endfunction

  // power-on RAM contents
  function automatic logic [7:0] fill_byte(input logic pattern, input logic [15:0] a);
    logic [7:0] v;
    if (a >= SCREEN_LO && a < SCREEN_END) v = SCREEN_VAL;
    else if (pattern) v = a[7] ? 8'h00 : 8'hFF;
    else v = a[6] ? 8'hFF : 8'h00;
    return v;
  endfunction

endpackage

/* hdl/bsmd_decode.sv */
// Address decoder: bank map lookup, I/O page decode, memory enables.
// Depends on bsmd_pkg.
module bsmd_decode (
  input  logic           cmd,
  input  logic [15:0]    address,
  input  logic [2:0]     port_bits,
  input  logic           game_line,
  input  logic           exrom_line,
  output bsmd_pkg::dec_t dec
);

  logic [4:0]      idx;
  logic [3:0]      bank;
  bsmd_pkg::kind_t kind;

  assign idx  = {exrom_line, game_line, port_bits};
  assign bank = address[15:12];

  always_comb begin
    kind = (bank == 4'd0) ? bsmd_pkg::K_R
                          : bsmd_pkg::REGION_MAP[idx][bsmd_pkg::bank_col(bank)];
  end

  always_comb begin
    dec.target = bsmd_pkg::TGT_RAM;
    dec.dev    = address;
    dec.ram_en = 1'b0;
    dec.ram_we = 1'b0;
    dec.col_en = 1'b0;
    dec.col_we = 1'b0;
    dec.src    = cmd ? bsmd_pkg::SRC_WDATA : bsmd_pkg::SRC_NONE;
    if (address[15:1] == 15'd0) begin
      dec.target = address[0] ? bsmd_pkg::TGT_PORTDATA : bsmd_pkg::TGT_PORTDIR;
    end else begin
      unique case (kind)
        bsmd_pkg::K_R, bsmd_pkg::K_O: begin
          if (kind == bsmd_pkg::K_O && !cmd) begin
            dec.target = bsmd_pkg::TGT_ROM;
          end else begin
            dec.target = bsmd_pkg::TGT_RAM;
            dec.ram_en = 1'b1;
            dec.ram_we = cmd;
            if (!cmd) dec.src = bsmd_pkg::SRC_RAM;
          end
        end
        bsmd_pkg::K_L: dec.target = bsmd_pkg::TGT_CARTLO;
        bsmd_pkg::K_H: dec.target = bsmd_pkg::TGT_CARTHI;
        bsmd_pkg::K_N: begin
          dec.target = bsmd_pkg::TGT_OPENBUS;
          dec.src    = cmd ? bsmd_pkg::SRC_NONE : bsmd_pkg::SRC_OBUS;
        end
        bsmd_pkg::K_I: begin
          unique case (address[11:8]) inside
            [4'h0:4'h3]: begin
              dec.target = bsmd_pkg::TGT_VIC;
              dec.dev    = {10'd0, address[5:0]};
            end
            [4'h4:4'h7]: begin
              dec.target = bsmd_pkg::TGT_SID;
              dec.dev    = {11'd0, address[4:0]};
            end
            [4'h8:4'hB]: begin
              // offset from 0xD800 keeps only the low ten bits
              dec.target = bsmd_pkg::TGT_COLOR;
              dec.dev    = {6'd0, address[9:0]};
              dec.col_en = 1'b1;
              dec.col_we = cmd;
              if (!cmd) dec.src = bsmd_pkg::SRC_COLOR;
            end
            4'hC: begin
              dec.target = bsmd_pkg::TGT_CIA1;
              dec.dev    = {12'd0, address[3:0]};
            end
            4'hD: begin
              dec.target = bsmd_pkg::TGT_CIA2;
              dec.dev    = {12'd0, address[3:0]};
            end
            4'hE:    dec.target = bsmd_pkg::TGT_IO1;
            default: dec.target = bsmd_pkg::TGT_IO2;
          endcase
        end
        default: dec.target = bsmd_pkg::TGT_RAM;
      endcase
    end
  end

endmodule

/* hdl/bsmd_main_ram.sv */
// Main RAM, 64K x 8, with the power-on fill sweep and pattern register.
// Depends on bsmd_pkg.
module bsmd_main_ram (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_bit,
  input  logic        en,
  input  logic        we,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  output logic [7:0]  rdata,
  output logic        busy
);

  logic [7:0]  mem [65536];
  logic        pattern;
  logic [15:0] sweep;

  // fill sweep restarts on reset and on every pattern write
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= 1'b0;
      busy    <= 1'b1;
      sweep   <= '0;
    end else if (cfg_we) begin
      pattern <= cfg_bit;
      busy    <= 1'b1;
      sweep   <= '0;
    end else if (busy) begin
      sweep <= sweep + 16'd1;
      if (sweep == 16'hFFFF) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= bsmd_pkg::fill_byte(pattern, sweep);
    end else if (en) begin
      if (we) mem[addr] <= wdata;
      else rdata <= mem[addr];
    end
  end

endmodule

/* hdl/bsmd_color_ram.sv */
// Color RAM, 1024 x 4, one access per cycle, registered read.
// No dependencies.
module bsmd_color_ram (
  input  logic       clk,
  input  logic       en,
  input  logic       we,
  input  logic [9:0] addr,
  input  logic [3:0] wdata,
  output logic [3:0] rdata
);

  logic [3:0] mem [1024];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else rdata <= mem[addr];
    end
  end

endmodule

/* hdl/bank_switched_memory_decoder.sv */
// Bank-switched memory decoder top level: decode, RAM access, output stage.
// Depends on bsmd_pkg, bsmd_decode, bsmd_main_ram, bsmd_color_ram.
//
// One bus access is one item. The block accepts one item per clock while
// in_stall is low. An accepted item is decoded and its main or color RAM
// access issued as it enters stage 1; the registered RAM data is merged into
// the result as the item moves on to the output register, where the result
// sits until taken. A stalled output backs up through the one item in flight
// to in_stall. Writes land in RAM at the accept edge, so a read that follows
// a write to the same byte sees the new value. After reset and after every
// ram_pattern write the main RAM is refilled by a sweep over all 65536 bytes,
// one byte per cycle on the RAM write port; no item is accepted during the
// sweep. cfg_ready is always high.
module bank_switched_memory_decoder (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [2:0]  port_bits,
  input  logic        game_line,
  input  logic        exrom_line,
  input  logic [7:0]  open_bus,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  target,
  output logic [15:0] device_address,
  output logic [7:0]  out_data,
  output logic        data_valid,
  output logic        ultimax,
  // ram_pattern register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  bsmd_pkg::dec_t dec;
  logic           accept;
  logic           out_load;
  logic           fill_busy;
  logic [7:0]     ram_rdata;
  logic [3:0]     col_rdata;

  // in-flight item, waiting on RAM read data
  logic             s1_valid;
  bsmd_pkg::src_t   s1_src;
  logic [3:0]       s1_target;
  logic [15:0]      s1_dev;
  logic [7:0]       s1_wdata;
  logic [7:0]       s1_obus;
  logic             s1_ultimax;
  logic [7:0]       s1_data;

  assign cfg_ready = 1'b1;

  // output register frees when empty or being taken
  assign out_load = !out_valid || !out_stall;
  assign in_stall = fill_busy || (s1_valid && !out_load);
  assign accept   = in_valid && !in_stall;

  bsmd_decode u_decode (
    .cmd        (cmd),
    .address    (address),
    .port_bits  (port_bits),
    .game_line  (game_line),
    .exrom_line (exrom_line),
    .dec        (dec)
  );

  bsmd_main_ram u_main_ram (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_valid && cfg_ready),
    .cfg_bit(cfg_data),
    .en     (accept && dec.ram_en),
    .we     (dec.ram_we),
    .addr   (address),
    .wdata  (write_data),
    .rdata  (ram_rdata),
    .busy   (fill_busy)
  );

  bsmd_color_ram u_color_ram (
    .clk   (clk),
    .en    (accept && dec.col_en),
    .we    (dec.col_we),
    .addr  (dec.dev[9:0]),
    .wdata (write_data[3:0]),
    .rdata (col_rdata)
  );

  // stage 1: capture decode while the RAM read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src     <= dec.src;
      s1_target  <= dec.target;
      s1_dev     <= dec.dev;
      s1_wdata   <= write_data;
      s1_obus    <= open_bus;
      s1_ultimax <= exrom_line && !game_line;
    end
  end

  // result byte: RAM data, color nibble under open-bus high nibble, etc.
  always_comb begin
    case (s1_src)
      bsmd_pkg::SRC_RAM:   s1_data = ram_rdata;
      bsmd_pkg::SRC_COLOR: s1_data = {s1_obus[7:4], col_rdata};
      bsmd_pkg::SRC_OBUS:  s1_data = s1_obus;
      bsmd_pkg::SRC_WDATA: s1_data = s1_wdata;
      default:             s1_data = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      target         <= s1_target;
      device_address <= s1_dev;
      out_data       <= s1_data;
      data_valid     <= (s1_src != bsmd_pkg::SRC_NONE);
      ultimax        <= s1_ultimax;
    end
  end

  // a pattern write always starts a fresh fill sweep
  a_cfg_fill: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> fill_busy)
    else $error("pattern write did not start fill sweep");

  // no item may reach the RAMs while the fill sweep owns the write port
  a_fill_lock: assert property (@(posedge clk) disable iff (rst)
    fill_busy |-> !accept)
    else $error("item accepted during fill sweep");

  // a blocked in-flight item is kept, not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid)
    else $error("in-flight item lost under output stall");

  // with both stages full and blocked, input must be stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input not stalled with pipeline full");

endmodule

/* tb/bsmd_scoreboard.sv */
// Bus-access and result types plus the scoreboard for the bank-switched memory decoder
// testbench: it predicts each access against its own RAM images and checks results in order.
// Depends on bsmd_pkg for the target codes.
package bsmd_tb_pkg;
  import bsmd_pkg::*;

  typedef struct {
    bit        cmd;
    bit [15:0] addr;
    bit [7:0]  wdata;
    bit [2:0]  port;
    bit        game;
    bit        exrom;
    bit [7:0]  obus;
  } access_t;

  typedef struct {
    target_t   tgt;
    bit [15:0] dev;
    bit [7:0]  data;
    bit        dv;
    bit        umax;
  } result_t;

  // what a 4 KB bank maps to
  typedef enum bit [2:0] {BK_R, BK_O, BK_I, BK_L, BK_H, BK_N} bank_src_e;

  // row {exrom, game, port}; columns: banks 1-7, 8-9, A-B, C, D, E-F
  localparam bank_src_e BANK_MAP [32][6] = '{
    '{BK_R,BK_R,BK_R,BK_R,BK_R,BK_R}, '{BK_R,BK_R,BK_R,BK_R,BK_R,BK_R},
    '{BK_R,BK_R,BK_H,BK_R,BK_O,BK_O}, '{BK_R,BK_L,BK_H,BK_R,BK_O,BK_O},
    '{BK_R,BK_R,BK_R,BK_R,BK_R,BK_R}, '{BK_R,BK_R,BK_R,BK_R,BK_I,BK_R},
    '{BK_R,BK_R,BK_H,BK_R,BK_I,BK_O}, '{BK_R,BK_L,BK_H,BK_R,BK_I,BK_O},
    '{BK_R,BK_R,BK_R,BK_R,BK_R,BK_R}, '{BK_R,BK_R,BK_R,BK_R,BK_O,BK_R},
    '{BK_R,BK_R,BK_R,BK_R,BK_O,BK_O}, '{BK_R,BK_L,BK_O,BK_R,BK_O,BK_O},
    '{BK_R,BK_R,BK_R,BK_R,BK_R,BK_R}, '{BK_R,BK_R,BK_R,BK_R,BK_I,BK_R},
    '{BK_R,BK_R,BK_R,BK_R,BK_I,BK_O}, '{BK_R,BK_L,BK_O,BK_R,BK_I,BK_O},
    '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H}, '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H},
    '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H}, '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H},
    '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H}, '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H},
    '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H}, '{BK_N,BK_L,BK_N,BK_N,BK_I,BK_H},
    '{BK_R,BK_R,BK_R,BK_R,BK_R,BK_R}, '{BK_R,BK_R,BK_R,BK_R,BK_O,BK_R},
    '{BK_R,BK_R,BK_R,BK_R,BK_O,BK_O}, '{BK_R,BK_R,BK_O,BK_R,BK_O,BK_O},
    '{BK_R,BK_R,BK_R,BK_R,BK_R,BK_R}, '{BK_R,BK_R,BK_R,BK_R,BK_I,BK_R},
    '{BK_R,BK_R,BK_R,BK_R,BK_I,BK_O}, '{BK_R,BK_R,BK_O,BK_R,BK_I,BK_O}
  };

  localparam int PRINT_CAP = 40;

  class bus_scoreboard;
    bit [7:0]  ram_image [65536];
    bit [3:0]  color_image [1024];
    bit        color_known [1024];
    bit [9:0]  color_written [$];
    result_t   expected_q [$];
    int        errors;
    int        n_checked;

    function new();
      refill(1'b0);
    endfunction

    // power-on fill; color RAM is not touched
    function void refill(bit inverted);
      for (int i = 0; i < 65536; i++) begin
        if (i >= 'h400 && i < 'h7E8) ram_image[i] = 8'h01;
        else if (inverted) ram_image[i] = i[7] ? 8'h00 : 8'hFF;
        else ram_image[i] = i[6] ? 8'hFF : 8'h00;
      end
    endfunction

    function bank_src_e bank_source(bit [15:0] addr, bit [4:0] row);
      int col;
      case (addr[15:12])
        4'h0: return BK_R;
        4'h8, 4'h9: col = 1;
        4'hA, 4'hB: col = 2;
        4'hC: col = 3;
        4'hD: col = 4;
        4'hE, 4'hF: col = 5;
        default: col = 0;
      endcase
      return BANK_MAP[row][col];
    endfunction

    // a read of a color cell nobody has written yet
    function bit hits_unknown_color(access_t a);
      bit [15:0] off;
      off = a.addr - 16'hD800;
      return !a.cmd && bank_source(a.addr, {a.exrom, a.game, a.port}) == BK_I &&
             a.addr[11:10] == 2'b10 && !color_known[off[9:0]];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_access(access_t a);
      result_t   r;
      bank_src_e src;
      bit [15:0] off;
      r.dev  = a.addr;
      r.data = 8'h00;
      r.dv   = 1'b0;
      r.umax = a.exrom & ~a.game;
      if (a.addr < 16'd2) begin
        r.tgt = a.addr[0] ? TGT_PORTDATA : TGT_PORTDIR;
      end else begin
        src = bank_source(a.addr, {a.exrom, a.game, a.port});
        case (src)
          BK_R, BK_O: begin
            if (src == BK_O && !a.cmd) begin
              r.tgt = TGT_ROM;
            end else begin
              r.tgt = TGT_RAM;
              if (a.cmd) ram_image[a.addr] = a.wdata;
              else begin
                r.data = ram_image[a.addr];
                r.dv = 1'b1;
              end
            end
          end
          BK_L: r.tgt = TGT_CARTLO;
          BK_H: r.tgt = TGT_CARTHI;
          BK_N: begin
            r.tgt = TGT_OPENBUS;
            if (!a.cmd) begin
              r.data = a.obus;
              r.dv = 1'b1;
            end
          end
          default: begin
            case (a.addr[11:8])
              4'h0, 4'h1, 4'h2, 4'h3: begin
                r.tgt = TGT_VIC;
                r.dev = a.addr & 16'h003F;
              end
              4'h4, 4'h5, 4'h6, 4'h7: begin
                r.tgt = TGT_SID;
                r.dev = a.addr & 16'h001F;
              end
              4'hC: begin
                r.tgt = TGT_CIA1;
                r.dev = a.addr & 16'h000F;
              end
              4'hD: begin
                r.tgt = TGT_CIA2;
                r.dev = a.addr & 16'h000F;
              end
              4'hE: r.tgt = TGT_IO1;
              4'hF: r.tgt = TGT_IO2;
              default: begin
                r.tgt = TGT_COLOR;
                off = a.addr - 16'hD800;
                r.dev = {6'd0, off[9:0]};
                if (a.cmd) begin
                  color_image[off[9:0]] = a.wdata[3:0];
                  if (!color_known[off[9:0]]) color_written.push_back(off[9:0]);
                  color_known[off[9:0]] = 1'b1;
                end else begin
                  r.data = {a.obus[7:4], color_image[off[9:0]]};
                  r.dv = 1'b1;
                end
              end
            endcase
          end
        endcase
      end
      if (a.cmd && r.tgt != TGT_OPENBUS) begin
        r.data = a.wdata;
        r.dv = 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH %0d: %s", errors, msg);
    endtask

    task check_result(result_t got);
      result_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with none expected", n_checked));
        return;
      end
      e = expected_q.pop_front();
      if (got.tgt != e.tgt)
        report($sformatf("result %0d target %0d, expected %s", n_checked, got.tgt,
                         e.tgt.name()));
      if (got.dev != e.dev)
        report($sformatf("result %0d device_address %h, expected %h", n_checked, got.dev,
                         e.dev));
      if (got.data != e.data)
        report($sformatf("result %0d out_data %h, expected %h", n_checked, got.data, e.data));
      if (got.dv != e.dv)
        report($sformatf("result %0d data_valid %b, expected %b", n_checked, got.dv, e.dv));
      if (got.umax != e.umax)
        report($sformatf("result %0d ultimax %b, expected %b", n_checked, got.umax, e.umax));
    endtask
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for bank_switched_memory_decoder: directed and random bus accesses,
// random idling on both channels, ram_pattern rewrites between phases.
// Depends on bsmd_pkg, bsmd_tb_pkg (scoreboard) and the decoder RTL.
module tb_top;
  import bsmd_pkg::*;
  import bsmd_tb_pkg::*;

  // The block refills main RAM with a sweep over all 65536 bytes after reset
  // and after every ram_pattern write, accepting nothing meanwhile, so the
  // stall limit has to clear one full sweep with room to spare.
  localparam int STALL_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 430;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PCT      = 13;
  localparam int RECENT_DEPTH  = 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [2:0]  port_bits;
  logic        game_line;
  logic        exrom_line;
  logic [7:0]  open_bus;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  target;
  logic [15:0] device_address;
  logic [7:0]  out_data;
  logic        data_valid;
  logic        ultimax;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  bus_scoreboard sb = new();

  bit        idle_on;       // random idling on both channels
  bit        hold_request;  // asks the receiver for one long hold-off
  bit [15:0] recent_addr [$];
  int        quiet_cycles;

  bank_switched_memory_decoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .address        (address),
    .write_data     (write_data),
    .port_bits      (port_bits),
    .game_line      (game_line),
    .exrom_line     (exrom_line),
    .open_bus       (open_bus),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .target         (target),
    .device_address (device_address),
    .out_data       (out_data),
    .data_valid     (data_valid),
    .ultimax        (ultimax),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Build one access; keeps the directed list readable.
  function automatic access_t acc(bit c, bit [15:0] a, bit [7:0] wd, bit [2:0] p,
                                  bit g, bit x, bit [7:0] ob);
    access_t t;
    t.cmd = c;
    t.addr = a;
    t.wdata = wd;
    t.port = p;
    t.game = g;
    t.exrom = x;
    t.obus = ob;
    return t;
  endfunction

  // Random access, weighted toward the I/O page, the port registers, the
  // screen area and addresses touched recently (so writes get read back,
  // often under a different bank setting).
  function automatic access_t random_access();
    access_t t;
    int      sel;
    t = acc(1'($urandom), 16'($urandom), 8'($urandom), 3'($urandom), 1'($urandom),
            1'($urandom), 8'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 20 && recent_addr.size() != 0)
      t.addr = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
    else if (sel < 40) t.addr = 16'hD000 | 16'($urandom_range(0, 'hFFF));
    else if (sel < 45) t.addr = 16'($urandom_range(0, 3));
    else if (sel < 52) t.addr = 16'h0400 + 16'($urandom_range(0, 'h3FF));
    // color cells are undefined until written: steer such reads to a known
    // cell, or turn them into writes while none is known yet
    if (sb.hits_unknown_color(t)) begin
      if (sb.color_written.size() != 0)
        t.addr = 16'hD800 + 16'(sb.color_written[$urandom_range(0, sb.color_written.size() - 1)]);
      else t.cmd = 1'b1;
    end
    return t;
  endfunction

  // Offer one item, starting at a falling edge; returns at the falling edge
  // after it was taken. The prediction is made right at the accept edge.
  task automatic send_access(access_t t);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= t.cmd;
    address    <= t.addr;
    write_data <= t.wdata;
    port_bits  <= t.port;
    game_line  <= t.game;
    exrom_line <= t.exrom;
    open_bus   <= t.obus;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_access(t);
    recent_addr.push_back(t.addr);
    if (recent_addr.size() > RECENT_DEPTH) void'(recent_addr.pop_front());
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // ram_pattern write; only called with nothing in flight
  task automatic write_pattern(bit v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.refill(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase. The first phase carries a long stretch with no idling
  // and the long receiver hold-off; the second has the sender pause until
  // everything has come back.
  task automatic random_phase(int phase);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (phase == 0 && n == 50) idle_on = 1'b0;
      if (phase == 0 && n == 200) idle_on = 1'b1;
      if (phase == 0 && n == 250) hold_request = 1'b1;
      if (phase == 1 && n == 200) drain();
      send_access(random_access());
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request while the
  // sender keeps offering, so the pipe fills and backs up to in_stall.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= idle_on && $urandom_range(0, 99) < IDLE_PCT;
    end
  end

  // Result monitor: sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{tgt: target_t'(target), dev: device_address, data: out_data,
                        dv: data_valid, umax: ultimax});
  end

  // Watchdog: cycles in a row with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("** bank_switched_memory_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    access_t directed [$];
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = 1'b0;
    address      = 16'h0000;
    write_data   = 8'h00;
    port_bits    = 3'd0;
    game_line    = 1'b0;
    exrom_line   = 1'b0;
    open_bus     = 8'h00;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, default fill (stripes on bit 6).
    // port registers at 0 and 1
    directed.push_back(acc(0, 16'h0000, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(1, 16'h0001, 8'hFF, 3'd7, 1, 1, 8'h00));
    // fill pattern and the screen block edges
    directed.push_back(acc(0, 16'h0002, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'h0040, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'h0400, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'h07E7, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'h07E8, 8'h00, 3'd7, 1, 1, 8'h00));
    // ROM read, write under ROM lands in RAM, read it back with all-RAM map
    directed.push_back(acc(0, 16'hA000, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(1, 16'hA123, 8'h5A, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'hA123, 8'h00, 3'd0, 1, 1, 8'h00));
    // I/O page: VIC and SID masking
    directed.push_back(acc(0, 16'hD020, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(1, 16'hD3FF, 8'h12, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(1, 16'hD7FF, 8'h34, 3'd7, 1, 1, 8'h00));
    // color RAM at both ends, upper nibble from the open bus
    directed.push_back(acc(1, 16'hD800, 8'hA7, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'hD800, 8'h00, 3'd7, 1, 1, 8'hC3));
    directed.push_back(acc(1, 16'hDBFF, 8'hFF, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'hDBFF, 8'h00, 3'd7, 1, 1, 8'h00));
    // CIAs and the two expansion pages
    directed.push_back(acc(0, 16'hDCFF, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(1, 16'hDDF0, 8'h80, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'hDE00, 8'h00, 3'd7, 1, 1, 8'h00));
    directed.push_back(acc(0, 16'hDFFF, 8'h00, 3'd7, 1, 1, 8'h00));
    // 16K cartridge: low and high windows
    directed.push_back(acc(0, 16'h8000, 8'h00, 3'd7, 0, 0, 8'h00));
    directed.push_back(acc(0, 16'hA000, 8'h00, 3'd7, 0, 0, 8'h00));
    // ultimax: open-bus read, dropped open-bus write, cart high write
    directed.push_back(acc(0, 16'h1000, 8'h00, 3'd0, 0, 1, 8'hFF));
    directed.push_back(acc(1, 16'hC000, 8'hAA, 3'd0, 0, 1, 8'h55));
    directed.push_back(acc(1, 16'hFFFF, 8'hFF, 3'd0, 0, 1, 8'h00));
    directed.push_back(acc(0, 16'hFFFF, 8'h00, 3'd0, 0, 0, 8'hFF));
    foreach (directed[i]) send_access(directed[i]);

    // Random phases, each behind a ram_pattern rewrite: inverted, plain,
    // inverted again.
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      write_pattern(phase != 1);
      random_phase(phase);
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("** bank_switched_memory_decoder: PASSED **");
    else
      $display("** bank_switched_memory_decoder: FAILED **");
    $finish;
  end

endmodule
